// File: hdl/sept_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sept_pkg
// Shared constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package sept_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_FRAC_BITS  = 15;

    localparam int CFG_W    = 12;
    localparam int PIX_W    = 8;
    localparam int IDX_W    = 22;
    localparam int TNS_W    = 16;
    localparam int GRAD_W   = 11;
    localparam int MAG_W    = 10;
    localparam int PROD_W   = 20;
    localparam int G2_W     = 21;
    localparam int POS_W    = 15;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 72;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;
        logic load;
        logic mask;
        logic grad;
        logic prod;
        logic start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mask_empty;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: hdl/sobel_edge_projection_tensor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_projection_tensor
// Streams gray/segmentation pixel pairs; emits the gradient projection tensor
// at every segmentation edge pixel.
//
// Input channel s_*: one pixel pair per transaction, tuser marks frame start.
// Output channel m_*: one result per edge centre, tlast closes the results of
// one input pixel, tuser flags the last pixel of the frame.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata, 0 = image width, 1 = image height.
// Results trail the input by one row and one column; the right column and
// the bottom row are flushed during the row ends and the last row.
// A pixel passes load, mask and check; each result adds gradient, product,
// divide and emit, with bit-serial dividers (one quotient bit a cycle).
// Pixels are handled one at a time; a result in the output register waits
// for m_tready while the next pixel is taken in. A stalled receiver stops the
// block at its next result. Reset clears position, windows and registers to
// 640 x 480; line stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_projection_tensor #(
    parameter int MAX_WIDTH  = sept_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sept_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = sept_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [sept_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sept_pkg::S_DATA_W-1:0] s_tdata,   // gray_pixel, seg_pixel
    input  wire logic                          s_tuser,   // frame_start
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sept_pkg::M_DATA_W-1:0]      m_tdata,   // pixel_index, tensor_xx,
                                                          // tensor_xy, tensor_yy, pad
    output logic                               m_tlast,   // run_last
    output logic                               m_tuser    // frame_done
);
    import sept_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [IDX_W-1:0]        pixel_index;
    logic [TNS_W-1:0]        tensor_xx, tensor_yy;
    logic signed [TNS_W-1:0] tensor_xy;

    sept_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sept_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .gray_in     (s_tdata[PIX_W-1:0]),
        .seg_in      (s_tdata[2*PIX_W-1:PIX_W]),
        .frame_start (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .pixel_index (pixel_index),
        .tensor_xx   (tensor_xx),
        .tensor_xy   (tensor_xy),
        .tensor_yy   (tensor_yy),
        .run_last    (m_tlast),
        .frame_done  (m_tuser)
    );

    assign m_tdata = {2'b00, tensor_yy, tensor_xy, tensor_xx, pixel_index};

endmodule
`default_nettype wire

// File: hdl/sept_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sept_ctrl
// Sequencer: one pixel transaction at a time, one result after another.
// ----------------------------------------------------------------------------
module sept_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire sept_pkg::stat_t stat,
    output sept_pkg::cmd_t      cmd
);
    import sept_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_MASK  = 8'b0000_0100,
        ST_CHECK = 8'b0000_1000,
        ST_PROD  = 8'b0001_0000,
        ST_G2    = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_MASK;
            end
            ST_MASK: begin
                cmd.mask   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.mask_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.grad   = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_G2;
            end
            ST_G2: begin
                cmd.start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/sept_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sept_div
// Restoring divider, one quotient bit per cycle, round half up.
// ----------------------------------------------------------------------------
module sept_div #(
    parameter int FRAC_BITS = sept_pkg::DEF_FRAC_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [sept_pkg::G2_W-1:0] num,
    input  wire logic [sept_pkg::G2_W-1:0] den,
    output logic                           busy,
    output logic [FRAC_BITS:0]             quot
);
    import sept_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int NW    = G2_W + QW;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [NW-1:0]    dividend;
    logic [G2_W:0]    trial;
    logic [G2_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]    lo_reg, lo_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [G2_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    assign dividend = (NW'(num) << FRAC_BITS) + NW'(den >> 1);
    assign trial    = {rem_reg, lo_reg[QW-1]};

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = dividend[NW-1:QW];
            lo_next   = dividend[QW-1:0];
            den_next  = den;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            lo_next = lo_reg << 1;
            if (trial >= {1'b0, den_reg}) begin
                rem_next = G2_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial[G2_W-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// File: hdl/sept_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sept_dpath
// Line stores, 3x3 windows, Sobel, products, dividers and output register.
// ----------------------------------------------------------------------------
module sept_dpath #(
    parameter int MAX_WIDTH  = sept_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sept_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = sept_pkg::DEF_FRAC_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_addr,
    input  wire logic [sept_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic [sept_pkg::PIX_W-1:0] gray_in,
    input  wire logic [sept_pkg::PIX_W-1:0] seg_in,
    input  wire logic                       frame_start,
    input  wire sept_pkg::cmd_t             cmd,
    output sept_pkg::stat_t                 stat,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic [sept_pkg::IDX_W-1:0]      pixel_index,
    output logic [sept_pkg::TNS_W-1:0]      tensor_xx,
    output logic signed [sept_pkg::TNS_W-1:0] tensor_xy,
    output logic [sept_pkg::TNS_W-1:0]      tensor_yy,
    output logic                            run_last,
    output logic                            frame_done
);
    import sept_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int QW = FRAC_BITS + 1;

    typedef logic [8:0][PIX_W-1:0] win_t;
    typedef logic [2:0][1:0] sel3_t;
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } grad_t;

    function automatic grad_t sobel(input win_t w, input sel3_t rm, input sel3_t cm);
        logic signed [GRAD_W-1:0] p [3][3];
        logic [3:0] ix;
        grad_t g;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ix = 4'(rm[i]) * 4'd3 + 4'(cm[j]);
                p[i][j] = $signed({3'b000, w[ix]});
            end
        end
        g.gx = (p[0][0] + (p[1][0] <<< 1) + p[2][0]) - (p[0][2] + (p[1][2] <<< 1) + p[2][2]);
        g.gy = (p[0][0] + (p[0][1] <<< 1) + p[0][2]) - (p[2][0] + (p[2][1] <<< 1) + p[2][2]);
        return g;
    endfunction

    function automatic sel3_t sel3(input logic signed [POS_W-1:0] ctr,
                                   input logic signed [POS_W-1:0] pos,
                                   input logic signed [POS_W-1:0] lim);
        logic signed [POS_W-1:0] v;
        sel3_t s;
        for (int d = 0; d < 3; d++) begin
            v = ctr - POS_W'(1) + POS_W'(d);
            if (v < 0) v = '0;
            if (v > lim) v = lim;
            s[d] = 2'(v + POS_W'(2) - pos);
        end
        return s;
    endfunction

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg == '0) ? DW'(1) :
                   (32'(width_reg) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_reg);
    assign h_eff = (height_reg == '0) ? HW'(1) :
                   (32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);

    // position
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] c_cur_reg;
    logic [RW-1:0] r_cur_reg;
    logic [CW-1:0] c_pos;
    logic [RW-1:0] r_pos;
    logic [PIX_W-1:0] gray_reg, seg_reg;
    int rt, ct;

    always_comb begin
        ct = int'(col_reg);
        rt = int'(row_reg);
        if (frame_start) begin
            ct = 0;
            rt = 0;
        end else if (ct >= int'(w_eff)) begin
            ct = 0;
            rt = rt + 1;
        end
        if (rt >= int'(h_eff)) rt = 0;
        c_pos = CW'(ct);
        r_pos = RW'(rt);
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load) begin
            if (32'(c_cur_reg) + 1 >= 32'(w_eff)) begin
                col_next = '0;
                if (32'(r_cur_reg) + 1 >= 32'(h_eff)) begin
                    row_next = '0;
                end else begin
                    row_next = r_cur_reg + 1'b1;
                end
            end else begin
                col_next = c_cur_reg + 1'b1;
                row_next = r_cur_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.accept) begin
            c_cur_reg <= c_pos;
            r_cur_reg <= r_pos;
            gray_reg  <= gray_in;
            seg_reg   <= seg_in;
        end
    end

    // line stores: {gray, seg} for rows r-1 and r-2
    logic [2*PIX_W-1:0] line1_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line2_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line1_rd_reg, line2_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            line1_rd_reg <= line1_mem[c_pos];
            line2_rd_reg <= line2_mem[c_pos];
        end
        if (cmd.load) begin
            line1_mem[c_cur_reg] <= {gray_reg, seg_reg};
            line2_mem[c_cur_reg] <= line1_rd_reg;
        end
    end

    // windows
    win_t gwin_reg, swin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gwin_reg <= '0;
            swin_reg <= '0;
        end else if (cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                gwin_reg[k*3]   <= gwin_reg[k*3+1];
                gwin_reg[k*3+1] <= gwin_reg[k*3+2];
                swin_reg[k*3]   <= swin_reg[k*3+1];
                swin_reg[k*3+1] <= swin_reg[k*3+2];
            end
            gwin_reg[2] <= line2_rd_reg[2*PIX_W-1:PIX_W];
            gwin_reg[5] <= line1_rd_reg[2*PIX_W-1:PIX_W];
            gwin_reg[8] <= gray_reg;
            swin_reg[2] <= line2_rd_reg[PIX_W-1:0];
            swin_reg[5] <= line1_rd_reg[PIX_W-1:0];
            swin_reg[8] <= seg_reg;
        end
    end

    // centres: bit k = {row offset, column offset}
    logic signed [POS_W-1:0] r_s, c_s, hm1, wm1;
    sel3_t rm_k [4];
    sel3_t cm_k [4];
    logic [3:0] place_ok, seg_edge;
    grad_t sg;

    assign r_s = $signed(POS_W'(r_cur_reg));
    assign c_s = $signed(POS_W'(c_cur_reg));
    assign hm1 = $signed(POS_W'(h_eff)) - POS_W'(1);
    assign wm1 = $signed(POS_W'(w_eff)) - POS_W'(1);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rm_k[k] = sel3(r_s - POS_W'(1) + POS_W'(k / 2), r_s, hm1);
            cm_k[k] = sel3(c_s - POS_W'(1) + POS_W'(k % 2), c_s, wm1);
            place_ok[k] = ((k / 2 == 0) ? (r_s >= POS_W'(1)) : (r_s == hm1)) &&
                          ((k % 2 == 0) ? (c_s >= POS_W'(1)) : (c_s == wm1));
            sg = sobel(swin_reg, rm_k[k], cm_k[k]);
            seg_edge[k] = (sg.gx != '0) || (sg.gy != '0);
        end
    end

    logic [3:0] mask_reg, mask_next;
    logic [3:0] low_bit;
    logic [1:0] k_sel;

    assign low_bit = mask_reg & (~mask_reg + 4'd1);

    always_comb begin
        priority if (low_bit[0]) k_sel = 2'd0;
        else if (low_bit[1]) k_sel = 2'd1;
        else if (low_bit[2]) k_sel = 2'd2;
        else k_sel = 2'd3;
    end

    always_comb begin
        mask_next = mask_reg;
        if (cmd.mask) begin
            mask_next = place_ok & seg_edge;
        end else if (cmd.emit) begin
            mask_next = mask_reg & ~low_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    // gradient stage
    grad_t gg, grad_reg;
    logic [RW-1:0] cr_reg;
    logic [CW-1:0] cc_reg;
    logic last_reg, done_reg;
    logic signed [POS_W-1:0] cr_s, cc_s;

    assign gg   = sobel(gwin_reg, rm_k[k_sel], cm_k[k_sel]);
    assign cr_s = r_s - POS_W'(1) + POS_W'(k_sel[1]);
    assign cc_s = c_s - POS_W'(1) + POS_W'(k_sel[0]);

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            grad_reg <= gg;
            cr_reg   <= RW'(cr_s);
            cc_reg   <= CW'(cc_s);
            last_reg <= ((mask_reg & ~low_bit) == '0);
            done_reg <= (cr_s == hm1) && (cc_s == wm1);
        end
    end

    // product stage
    logic [MAG_W-1:0]   ax, ay;
    logic [PROD_W-1:0]  pxx_reg, pyy_reg, pxy_reg;
    logic [RW+DW-1:0]   idx_prod_reg;
    logic               neg_reg, flat_reg;

    assign ax = grad_reg.gx[GRAD_W-1] ? MAG_W'(-grad_reg.gx) : MAG_W'(grad_reg.gx);
    assign ay = grad_reg.gy[GRAD_W-1] ? MAG_W'(-grad_reg.gy) : MAG_W'(grad_reg.gy);

    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            pxx_reg      <= ax * ax;
            pyy_reg      <= ay * ay;
            pxy_reg      <= ax * ay;
            idx_prod_reg <= cr_reg * w_eff;
            neg_reg      <= (grad_reg.gx[GRAD_W-1] == grad_reg.gy[GRAD_W-1]);
            flat_reg     <= (grad_reg.gx == '0) && (grad_reg.gy == '0);
        end
    end

    // norm and divide
    logic [G2_W-1:0]  g2, den;
    logic [IDX_W-1:0] idx_reg;
    logic [QW-1:0]    q_xx, q_xy, q_yy;
    logic             busy_xx, busy_xy, busy_yy;

    assign g2  = G2_W'(pxx_reg) + G2_W'(pyy_reg);
    assign den = flat_reg ? G2_W'(1) : g2;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            idx_reg <= IDX_W'(idx_prod_reg + (RW+DW)'(cc_reg));
        end
    end

    sept_div #(.FRAC_BITS(FRAC_BITS)) u_div_xx (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .num(G2_W'(pyy_reg)), .den(den), .busy(busy_xx), .quot(q_xx)
    );
    sept_div #(.FRAC_BITS(FRAC_BITS)) u_div_xy (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .num(G2_W'(pxy_reg)), .den(den), .busy(busy_xy), .quot(q_xy)
    );
    sept_div #(.FRAC_BITS(FRAC_BITS)) u_div_yy (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .num(G2_W'(pxx_reg)), .den(den), .busy(busy_yy), .quot(q_yy)
    );

    // saturation and output register
    logic [TNS_W-1:0] xx_val, xy_val, yy_val;
    logic [31:0]      m_xy;

    always_comb begin
        if (flat_reg) begin
            xx_val = '0;
            xy_val = '0;
            yy_val = (32'(1) << FRAC_BITS) > 32'd65535 ? 16'hFFFF
                                                       : TNS_W'(32'(1) << FRAC_BITS);
            m_xy   = '0;
        end else begin
            xx_val = (32'(q_xx) > 32'd65535) ? 16'hFFFF : TNS_W'(q_xx);
            yy_val = (32'(q_yy) > 32'd65535) ? 16'hFFFF : TNS_W'(q_yy);
            if (neg_reg) begin
                m_xy   = (32'(q_xy) > 32'd32768) ? 32'd32768 : 32'(q_xy);
                xy_val = TNS_W'(32'd0 - m_xy);
            end else begin
                m_xy   = (32'(q_xy) > 32'd32767) ? 32'd32767 : 32'(q_xy);
                xy_val = TNS_W'(m_xy);
            end
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            pixel_index <= idx_reg;
            tensor_xx   <= xx_val;
            tensor_xy   <= $signed(xy_val);
            tensor_yy   <= yy_val;
            run_last    <= last_reg;
            frame_done  <= done_reg;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign stat.mask_empty = (mask_reg == '0);
    assign stat.div_done   = !(busy_xx || busy_xy || busy_yy);
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule
`default_nettype wire
